@@ hdl/pbp_pkg.sv @@
// shared constants and controller/datapath interface types of the perceptron predictor
package pbp_pkg;

  localparam int unsigned ADDR_W              = 32;
  localparam int unsigned COUNT_W             = 32;
  localparam int unsigned THRESH_W            = 8;
  localparam int unsigned DIV_STEPS           = 2;  // quotient, then remainder
  localparam int unsigned ROW_COUNT_DEF       = 52;
  localparam int unsigned INPUTS_PER_ROW_DEF  = 10;
  localparam int unsigned WEIGHT_BITS_DEF     = 16;
  localparam int unsigned BIAS_RESET          = 100;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd33;

  typedef struct packed {
    logic load;      // capture a new branch word
    logic clear_wr;  // write the reset row during the clearing pass
    logic div_step;  // one step of the row index remainder
    logic mem_rd;    // read the selected weight row
    logic acc_step;  // add one weight into the dot product
    logic update;    // decide, train and retire the branch
  } pbp_cmd_t;

  typedef struct packed {
    logic last;      // current sweep ends this cycle
  } pbp_status_t;

endpackage

@@ hdl/perceptron_branch_predictor_top.sv @@
// top level of the perceptron branch predictor
//
// One resolved branch word is taken when start is high and busy is low. The
// row index is the address modulo ROW_COUNT, worked out by a reciprocal
// multiplication and then a short multiply-subtract; the row is then read,
// its INPUTS_PER_ROW weights are summed one per cycle in a single
// accumulator, and a last step decides, trains and, if training is due,
// writes the row back. busy stays high through these steps, the result then
// follows on result_valid_o for one cycle, and the next word may be given in
// that same cycle. The result cannot be held off. After reset the weight
// memory is set by a clearing pass over all ROW_COUNT rows with busy high;
// threshold writes are taken throughout and must only come while the block
// is idle.
module perceptron_branch_predictor_top
  import pbp_pkg::*;
#(
  parameter int unsigned ROW_COUNT      = ROW_COUNT_DEF,
  parameter int unsigned INPUTS_PER_ROW = INPUTS_PER_ROW_DEF,
  parameter int unsigned WEIGHT_BITS    = WEIGHT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ADDR_W-1:0]   branch_address_i,
  input  logic                branch_taken_i,
  input  logic                cfg_we_i,
  input  logic [THRESH_W-1:0] training_threshold_i,
  output logic                result_valid_o,
  output logic                predicted_taken_o,
  output logic                prediction_correct_o,
  output logic                weights_trained_o,
  output logic [COUNT_W-1:0]  correct_total_o
);

  pbp_cmd_t    cmd;
  pbp_status_t status;

  pbp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (result_valid_o)
  );

  pbp_datapath #(
    .ROW_COUNT      (ROW_COUNT),
    .INPUTS_PER_ROW (INPUTS_PER_ROW),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .branch_address_i     (branch_address_i),
    .branch_taken_i       (branch_taken_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (training_threshold_i),
    .predicted_taken_o    (predicted_taken_o),
    .prediction_correct_o (prediction_correct_o),
    .weights_trained_o    (weights_trained_o),
    .correct_total_o      (correct_total_o)
  );

  // a misprediction always trains the row
  a_mispredict_trains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !prediction_correct_o |-> weights_trained_o)
    else $error("misprediction without training");

  // the running total moves by exactly the correctness of this word
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> correct_total_o ==
      COUNT_W'($past(correct_total_o) + {{(COUNT_W-1){1'b0}}, prediction_correct_o}))
    else $error("correct total out of step");

  // the total holds between results
  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o && !$past(result_valid_o) |-> $stable(correct_total_o) || $past(busy))
    else $error("correct total changed outside a branch");

endmodule

@@ hdl/pbp_ctrl.sv @@
// sequencer of the perceptron predictor: clearing pass, index, read, dot product, training
module pbp_ctrl
  import pbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  pbp_status_t status_i,
  output pbp_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        done_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_ACC,
    S_UPD
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.last) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_step = 1'b1;
        if (status_i.last) state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_UPD);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // an accepted word keeps the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted word did not make the block busy");

  // a result only appears once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // the result strobe is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

@@ hdl/pbp_datapath.sv @@
// datapath of the perceptron predictor: remainder unit, weight memory, accumulator, trainer
module pbp_datapath
  import pbp_pkg::*;
#(
  parameter int unsigned ROW_COUNT      = ROW_COUNT_DEF,
  parameter int unsigned INPUTS_PER_ROW = INPUTS_PER_ROW_DEF,
  parameter int unsigned WEIGHT_BITS    = WEIGHT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbp_cmd_t            cmd_i,
  output pbp_status_t         status_o,
  input  logic [ADDR_W-1:0]   branch_address_i,
  input  logic                branch_taken_i,
  input  logic                cfg_we_i,
  input  logic [THRESH_W-1:0] cfg_wdata_i,
  output logic                predicted_taken_o,
  output logic                prediction_correct_o,
  output logic                weights_trained_o,
  output logic [COUNT_W-1:0]  correct_total_o
);

  localparam int unsigned RowIdxW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned TapW    = $clog2(INPUTS_PER_ROW);
  localparam int unsigned HistW   = INPUTS_PER_ROW - 1;
  localparam int unsigned RowW    = INPUTS_PER_ROW * WEIGHT_BITS;
  localparam int unsigned SumW    = WEIGHT_BITS + TapW + 1;
  localparam int unsigned CntMax0 = (ROW_COUNT > INPUTS_PER_ROW) ? ROW_COUNT : INPUTS_PER_ROW;
  localparam int unsigned CntMax  = (CntMax0 > DIV_STEPS) ? CntMax0 : DIV_STEPS;
  localparam int unsigned CntW    = (CntMax > 1) ? $clog2(CntMax) : 1;

  // reciprocal of the row count, always between 2^32 and 2^33; only the low part is stored
  localparam int unsigned DivShift = ADDR_W + $clog2(ROW_COUNT);
  localparam logic [ADDR_W-1:0] RecipLo =
    ADDR_W'(((64'd1 << DivShift) + 64'(ROW_COUNT) - 64'd1) / 64'(ROW_COUNT));

  localparam logic signed [WEIGHT_BITS-1:0] WMax = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] WMin = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  logic [ADDR_W-1:0]             addr_q;
  logic                          taken_q;
  logic [2*ADDR_W-1:0]           prod_lo;
  logic [2*ADDR_W:0]             prod;
  logic [ADDR_W-1:0]             quot_q, quot_d;
  logic [RowIdxW-1:0]            rem_q, rem_d;
  logic [CntW-1:0]               cnt_q;
  logic [HistW-1:0]              hist_q;
  logic [HistW:0]                hist_sh;
  logic [COUNT_W-1:0]            total_q;
  logic [THRESH_W-1:0]           thresh_q;
  logic [RowW-1:0]               mem_q [ROW_COUNT];
  logic [RowW-1:0]               row_q;
  logic [RowW-1:0]               reset_row, new_row;
  logic signed [WEIGHT_BITS-1:0] wt [INPUTS_PER_ROW];
  logic [INPUTS_PER_ROW-1:0]     xin;
  logic [TapW-1:0]               tap;
  logic signed [WEIGHT_BITS-1:0] term;
  logic signed [SumW-1:0]        term_ext;
  logic signed [SumW-1:0]        sum_q, sum_d;
  logic [SumW-1:0]               mag;
  logic [RowIdxW-1:0]            row_idx, wr_idx;
  logic                          pred, correct, train, step, wr_en;

  // remainder by the row count: quotient by reciprocal multiplication in the first
  // step, then the low address bits less quotient times row count in the second
  assign prod_lo = {{ADDR_W{1'b0}}, addr_q} * {{ADDR_W{1'b0}}, RecipLo};
  assign prod    = {1'b0, addr_q, {ADDR_W{1'b0}}} + {1'b0, prod_lo};
  assign quot_d  = ADDR_W'(prod >> DivShift);
  assign rem_d   = addr_q[RowIdxW-1:0] - quot_q[RowIdxW-1:0] * RowIdxW'(ROW_COUNT);

  assign row_idx = rem_q;
  assign wr_idx  = cmd_i.clear_wr ? cnt_q[RowIdxW-1:0] : row_idx;

  // bias input is a constant +1, the rest is the bipolar history
  assign xin = {hist_q, 1'b1};
  assign tap = cnt_q[TapW-1:0];

  always_comb begin
    for (int i = 0; i < INPUTS_PER_ROW; i++) begin
      wt[i]                            = row_q[i*WEIGHT_BITS +: WEIGHT_BITS];
      reset_row[i*WEIGHT_BITS +: WEIGHT_BITS] = (i == 0) ? WEIGHT_BITS'(BIAS_RESET) : '0;
    end
  end

  assign term     = wt[tap];
  assign term_ext = {{(SumW-WEIGHT_BITS){term[WEIGHT_BITS-1]}}, term};
  assign sum_d    = xin[tap] ? (sum_q + term_ext) : (sum_q - term_ext);

  assign pred    = !sum_q[SumW-1] && (sum_q != '0);
  assign correct = (pred == taken_q);
  assign mag     = sum_q[SumW-1] ? (~sum_q + SumW'(1)) : sum_q;
  assign train   = !correct || (mag < {{(SumW-THRESH_W){1'b0}}, thresh_q});

  // each weight steps towards agreement with the outcome, saturating
  always_comb begin
    for (int i = 0; i < INPUTS_PER_ROW; i++) begin
      if (xin[i] == taken_q)
        new_row[i*WEIGHT_BITS +: WEIGHT_BITS] =
          (wt[i] == WMax) ? wt[i] : (wt[i] + WEIGHT_BITS'(1));
      else
        new_row[i*WEIGHT_BITS +: WEIGHT_BITS] =
          (wt[i] == WMin) ? wt[i] : (wt[i] - WEIGHT_BITS'(1));
    end
  end

  assign step  = cmd_i.clear_wr || cmd_i.div_step || cmd_i.acc_step;
  assign wr_en = cmd_i.clear_wr || (cmd_i.update && train);

  assign status_o.last =
    (cmd_i.clear_wr && (cnt_q == CntW'(ROW_COUNT - 1))) ||
    (cmd_i.div_step && (cnt_q == CntW'(DIV_STEPS - 1))) ||
    (cmd_i.acc_step && (cnt_q == CntW'(INPUTS_PER_ROW - 1)));

  assign hist_sh = {taken_q, hist_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= cmd_i.clear_wr ? reset_row : new_row;
    if (cmd_i.mem_rd) row_q <= mem_q[row_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= branch_address_i;
      taken_q <= branch_taken_i;
    end
    if (cmd_i.div_step) begin
      if (cnt_q == '0) quot_q <= quot_d;
      else rem_q <= rem_d;
    end
    if (cmd_i.mem_rd) sum_q <= '0;
    if (cmd_i.acc_step) sum_q <= sum_d;
    if (cmd_i.update) begin
      predicted_taken_o    <= pred;
      prediction_correct_o <= correct;
      weights_trained_o    <= train;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      hist_q   <= '1;
      total_q  <= '0;
      thresh_q <= THRESHOLD_RESET;
    end else begin
      if (step) cnt_q <= status_o.last ? '0 : (cnt_q + CntW'(1));
      if (cfg_we_i) thresh_q <= cfg_wdata_i;
      if (cmd_i.update) begin
        hist_q <= hist_sh[HistW:1];
        if (correct) total_q <= total_q + COUNT_W'(1);
      end
    end
  end

  assign correct_total_o = total_q;

endmodule
